FILE: hw/rtl/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef struct packed {
    mode_t                     mode;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  back_value;
    logic [4:0]                entry_count;
    status_t                   status;
  } result_t;

  typedef struct packed {
    logic put_front;
    logic put_back;
    logic take_front;
    logic take_back;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/dq_cell.sv
module dq_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  dq_pkg::cell_ctrl_t                ctrl,
  input  logic signed [dq_pkg::DATA_W-1:0]  prev_data,
  input  logic                              prev_valid,
  input  logic signed [dq_pkg::DATA_W-1:0]  next_data,
  input  logic                              next_valid,
  input  logic signed [dq_pkg::DATA_W-1:0]  push_value,
  output logic signed [dq_pkg::DATA_W-1:0]  data,
  output logic                              valid,
  output logic signed [dq_pkg::DATA_W-1:0]  tail_data
);

  logic is_tail;
  logic is_slot;

  assign is_tail   = valid && !next_valid;
  assign is_slot   = !valid && prev_valid;
  assign tail_data = is_tail ? data : '0;

  always_ff @(posedge clk) begin
    if (ctrl.put_front) begin
      data <= prev_data;
    end else if (ctrl.put_back && is_slot) begin
      data <= push_value;
    end else if (ctrl.take_front) begin
      data <= next_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.put_front) begin
      valid <= prev_valid;
    end else if (ctrl.put_back && is_slot) begin
      valid <= 1'b1;
    end else if (ctrl.take_front) begin
      valid <= next_valid;
    end else if (ctrl.take_back && is_tail) begin
      valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/double_ended_queue.sv
// Bounded deque of signed 32-bit words held in a row of DEPTH cells, cell 0
// at the front. One command word is taken in every clock cycle (busy stays
// low); the accepting edge sets pending, and pending then loads done and the
// result register together. The result word stays on result until the next
// command's result replaces it; the receiver cannot stall the block. Each cell
// updates from its two neighbors in the same cycle, so a push or pop at either
// end completes at the accepting edge; the following cycle picks the front cell
// and the tail cell into the result register. A pop on an empty queue and a
// push on a full queue leave the contents unchanged and are flagged in status.
module double_ended_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dq_pkg::cmd_t     cmd,
  output logic             done,
  output dq_pkg::result_t  result
);

  localparam int N = dq_pkg::DEPTH;

  logic                              accept;
  logic                              full;
  logic                              empty;
  dq_pkg::cell_ctrl_t                ctrl;
  dq_pkg::status_t                   status_next;
  logic [dq_pkg::CNT_W-1:0]          count;
  logic [dq_pkg::CNT_W-1:0]          count_next;
  logic                              pending;
  dq_pkg::status_t                   pending_status;
  logic signed [dq_pkg::DATA_W-1:0]  cell_data  [N];
  logic [N-1:0]                      cell_valid;
  logic signed [dq_pkg::DATA_W-1:0]  cell_tail  [N];
  logic signed [dq_pkg::DATA_W-1:0]  back_word;
  logic [N-1:0]                      thermo;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == dq_pkg::CNT_W'(N));
  assign empty  = (count == '0);

  always_comb begin
    ctrl        = '0;
    status_next = dq_pkg::ST_OK;
    count_next  = count;
    if (accept) begin
      case (cmd.mode)
        dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
          if (full) begin
            status_next = dq_pkg::ST_PUSH_FULL;
          end else begin
            ctrl.put_front = (cmd.mode == dq_pkg::MODE_PUSH_FRONT);
            ctrl.put_back  = (cmd.mode == dq_pkg::MODE_PUSH_BACK);
            count_next     = count + 1'b1;
          end
        end
        dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK: begin
          if (empty) begin
            status_next = dq_pkg::ST_POP_EMPTY;
          end else begin
            ctrl.take_front = (cmd.mode == dq_pkg::MODE_POP_FRONT);
            ctrl.take_back  = (cmd.mode == dq_pkg::MODE_POP_BACK);
            count_next      = count - 1'b1;
          end
        end
        default: begin
          status_next = dq_pkg::ST_OK;
        end
      endcase
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [dq_pkg::DATA_W-1:0] prev_d;
    logic                             prev_v;
    logic signed [dq_pkg::DATA_W-1:0] next_d;
    logic                             next_v;

    if (i == 0) begin : g_head
      assign prev_d = cmd.value;
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_d = cell_data[i-1];
      assign prev_v = cell_valid[i-1];
    end

    if (i == N - 1) begin : g_end
      assign next_d = cmd.value;
      assign next_v = 1'b0;
    end else begin : g_mid
      assign next_d = cell_data[i+1];
      assign next_v = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_data  (prev_d),
      .prev_valid (prev_v),
      .next_data  (next_d),
      .next_valid (next_v),
      .push_value (cmd.value),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .tail_data  (cell_tail[i])
    );
  end

  always_comb begin
    back_word = '0;
    for (int i = 0; i < N; i++) begin
      back_word = back_word | cell_tail[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      pending        <= 1'b0;
      pending_status <= dq_pkg::ST_OK;
      done           <= 1'b0;
    end else begin
      count          <= count_next;
      pending        <= accept;
      pending_status <= status_next;
      done           <= pending;
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      result.front_value <= empty ? dq_pkg::EMPTY_VALUE : cell_data[0];
      result.back_value  <= empty ? dq_pkg::EMPTY_VALUE : back_word;
      result.entry_count <= 5'(count);
      result.status      <= pending_status;
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      thermo[i] = (count > dq_pkg::CNT_W'(i));
    end
  end

  a_cells_match_count: assert property (@(posedge clk) disable iff (rst)
    cell_valid == thermo)
    else $error("cell valid bits disagree with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dq_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted command gave no result");

  a_empty_pop_flag: assert property (@(posedge clk) disable iff (rst)
    done && result.status == dq_pkg::ST_POP_EMPTY |-> result.entry_count == 5'd0
      && result.front_value == dq_pkg::EMPTY_VALUE)
    else $error("pop on empty reported with stored entries");

endmodule

FILE: test/tb_double_ended_queue.sv
class deque_scoreboard;
  logic signed [dq_pkg::DATA_W-1:0] contents[$];
  dq_pkg::result_t expected_results[$];
  int mismatches;
  int checked;
  int pushes;
  int pops;
  int full_drops;
  int empty_pops;

  function new();
    mismatches = 0;
    checked = 0;
    pushes = 0;
    pops = 0;
    full_drops = 0;
    empty_pops = 0;
  endfunction

  function void note_cmd(dq_pkg::cmd_t c);
    dq_pkg::result_t r;
    r.status = dq_pkg::ST_OK;
    case (c.mode)
      dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
        if (contents.size() >= dq_pkg::DEPTH) begin
          r.status = dq_pkg::ST_PUSH_FULL;
          full_drops++;
        end else begin
          if (c.mode == dq_pkg::MODE_PUSH_FRONT) contents.insert(0, c.value);
          else contents.insert(contents.size(), c.value);
          pushes++;
        end
      end
      default: begin
        if (contents.size() == 0) begin
          r.status = dq_pkg::ST_POP_EMPTY;
          empty_pops++;
        end else begin
          if (c.mode == dq_pkg::MODE_POP_FRONT) contents.delete(0);
          else contents.delete(contents.size() - 1);
          pops++;
        end
      end
    endcase
    if (contents.size() == 0) begin
      r.front_value = dq_pkg::EMPTY_VALUE;
      r.back_value = dq_pkg::EMPTY_VALUE;
    end else begin
      r.front_value = contents[0];
      r.back_value = contents[$];
    end
    r.entry_count = 5'(contents.size());
    expected_results.insert(expected_results.size(), r);
  endfunction

  task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h (result word %0d)", field, got, want, checked);
    mismatches++;
  endtask

  task check_result(dq_pkg::result_t r);
    dq_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result word", 32'(r), 32'h0);
    end else begin
      want = expected_results[0];
      expected_results.delete(0);
      if (r.front_value !== want.front_value)
        report_mismatch("front_value", r.front_value, want.front_value);
      if (r.back_value !== want.back_value)
        report_mismatch("back_value", r.back_value, want.back_value);
      if (r.entry_count !== want.entry_count)
        report_mismatch("entry_count", 32'(r.entry_count), 32'(want.entry_count));
      if (r.status !== want.status)
        report_mismatch("status", 32'(r.status), 32'(want.status));
      checked++;
    end
  endtask
endclass

module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 2000;
  localparam int QUIET_TAIL = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic done;
  dq_pkg::cmd_t cmd;
  dq_pkg::result_t result;
  int unsigned cycles = 0;
  deque_scoreboard sb;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_queue DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  task automatic send_word(dq_pkg::mode_t m, logic signed [dq_pkg::DATA_W-1:0] v);
    dq_pkg::cmd_t c;
    c.mode = m;
    c.value = v;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.note_cmd(c);
  endtask

  task automatic hold_idle(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [dq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sent;
    int phase_left;
    int push_pct;
    dq_pkg::mode_t m;
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_word(dq_pkg::MODE_POP_FRONT, 32'sd5);
    send_word(dq_pkg::MODE_POP_BACK, -32'sd5);
    send_word(dq_pkg::MODE_PUSH_FRONT, 32'sh8000_0000);
    send_word(dq_pkg::MODE_PUSH_BACK, 32'sh7FFF_FFFF);
    send_word(dq_pkg::MODE_POP_FRONT, '0);
    send_word(dq_pkg::MODE_POP_FRONT, '0);
    send_word(dq_pkg::MODE_PUSH_BACK, '0);
    send_word(dq_pkg::MODE_POP_BACK, '1);
    send_word(dq_pkg::MODE_PUSH_FRONT, '1);
    send_word(dq_pkg::MODE_PUSH_FRONT, 32'sd1);
    send_word(dq_pkg::MODE_PUSH_BACK, 32'sh5555_5555);
    send_word(dq_pkg::MODE_PUSH_BACK, 32'shAAAA_AAAA);
    send_word(dq_pkg::MODE_POP_BACK, '0);
    send_word(dq_pkg::MODE_POP_FRONT, '0);
    send_word(dq_pkg::MODE_POP_BACK, '0);
    send_word(dq_pkg::MODE_POP_FRONT, '0);
    send_word(dq_pkg::MODE_POP_BACK, '0);

    sent = 0;
    phase_left = 40;
    push_pct = 90;
    while (sent < RANDOM_WORDS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: push_pct = 90;
          1: push_pct = 50;
          default: push_pct = 10;
        endcase
      end
      if (sent < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        hold_idle($urandom_range(1, 18));
      if ($urandom_range(0, 99) < push_pct)
        m = $urandom_range(0, 1) ? dq_pkg::MODE_PUSH_BACK : dq_pkg::MODE_PUSH_FRONT;
      else
        m = $urandom_range(0, 1) ? dq_pkg::MODE_POP_BACK : dq_pkg::MODE_POP_FRONT;
      send_word(m, pick_value());
      sent++;
      phase_left--;
    end
    start <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pushes, %0d pops, %0d pushes on full, %0d pops on empty",
             sb.pushes, sb.pops, sb.full_drops, sb.empty_pops);
    $display("Checked %0d result words, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
